// File: rtl/cwj_pkg.sv
package cwj_pkg;

  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_NONZERO   = 2'd1;
  localparam logic [1:0] OP_EMPTY_ROW = 2'd2;

  localparam logic [1:0] ST_UPDATED   = 2'd0;
  localparam logic [1:0] ST_NO_DIAG   = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;
  // row ends that can be in the front pipeline but not yet queued
  localparam int FRONT_INFLIGHT = 3;

  typedef struct packed {
    logic               empty_row;
    logic [9:0]         row;
    logic signed [63:0] acc;
    logic signed [31:0] rhs;
    logic signed [31:0] oldx;
    logic signed [31:0] diag;
    logic               found;
  } job_t;

endpackage

// File: rtl/csr_weighted_jacobi_sweep_top.sv
// Weighted Jacobi sweep over a CSR matrix, Q16.16. Load x first (operation 0),
// then stream nonzeros (operation 1) or empty rows (operation 2). The front
// takes one beat per cycle: loads, nonzeros and empty rows all stream at one
// per cycle as long as the row-end queue has room. Each row end or empty row
// becomes one result; a row with a usable diagonal goes through the residual,
// multiply, prepare, bit-serial divide and fix-up steps of the back unit, other
// rows only through the residual step. full rises once the 8-entry row-end
// queue holds 5 jobs. x is never updated in place; new_x is only reported.
module csr_weighted_jacobi_sweep_top #(
  parameter int N_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [9:0]         index,
  input  logic [9:0]         row,
  input  logic signed [31:0] value,
  input  logic signed [31:0] rhs,
  input  logic               row_end,
  input  logic               omega_we,
  input  logic [17:0]        omega_wdata,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         out_row,
  output logic signed [31:0] residual,
  output logic signed [31:0] new_x,
  output logic [1:0]         status
);

  logic          accept, job_push, job_pop, job_ready;
  cwj_pkg::job_t job_f, job_q;
  logic [cwj_pkg::QUEUE_AW:0] qcount;

  assign full   = qcount >= (cwj_pkg::QUEUE_AW+1)'(cwj_pkg::QUEUE_DEPTH
                                                  - cwj_pkg::FRONT_INFLIGHT);
  assign accept = push && !full;

  cwj_front #(.N_ROWS(N_ROWS)) u_front (
    .clk, .rst, .accept, .operation, .index, .row, .value, .rhs, .row_end,
    .job_push, .job(job_f)
  );

  cwj_queue u_queue (
    .clk, .rst, .push(job_push), .din(job_f), .pop(job_pop), .dout(job_q),
    .nonempty(job_ready), .count(qcount)
  );

  cwj_back u_back (
    .clk, .rst, .omega_we, .omega_wdata, .job_ready, .job_in(job_q), .job_pop,
    .pop, .empty, .out_row, .residual, .new_x, .status
  );

endmodule

// File: rtl/cwj_front.sv
module cwj_front #(
  parameter int N_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         operation,
  input  logic [9:0]         index,
  input  logic [9:0]         row,
  input  logic signed [31:0] value,
  input  logic signed [31:0] rhs,
  input  logic               row_end,
  output logic               job_push,
  output cwj_pkg::job_t      job
);

  localparam int AW = (N_ROWS > 2) ? $clog2(N_ROWS) : 1;
  localparam int IW = (AW > 10) ? AW : 10;

  logic [31:0] xmem [N_ROWS];

  logic [IW-1:0] idx_ext, row_ext;
  logic          idx_ok, row_ok;

  assign idx_ext = IW'(index);
  assign row_ext = IW'(row);
  assign idx_ok  = 32'(index) < 32'(N_ROWS);
  assign row_ok  = 32'(row) < 32'(N_ROWS);

  // stage 1: store read
  logic               s1_v;
  logic [1:0]         s1_op;
  logic               s1_diag, s1_last, s1_iok, s1_rok;
  logic [9:0]         s1_row;
  logic signed [31:0] s1_val, s1_rhs;
  logic [31:0]        s1_xi, s1_xr;

  always_ff @(posedge clk) begin
    if (accept && operation == cwj_pkg::OP_LOAD && idx_ok) begin
      xmem[idx_ext[AW-1:0]] <= value;
    end
    s1_xi <= xmem[idx_ext[AW-1:0]];
    s1_xr <= xmem[row_ext[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept && (operation == cwj_pkg::OP_NONZERO ||
                         operation == cwj_pkg::OP_EMPTY_ROW);
    end
    s1_op   <= operation;
    s1_diag <= index == row;
    s1_last <= row_end;
    s1_iok  <= idx_ok;
    s1_rok  <= row_ok;
    s1_row  <= row;
    s1_val  <= value;
    s1_rhs  <= rhs;
  end

  // stage 2: product
  logic               s2_v;
  logic [1:0]         s2_op;
  logic               s2_diag, s2_last;
  logic [9:0]         s2_row;
  logic signed [31:0] s2_val, s2_rhs, s2_oldx;
  logic signed [63:0] s2_prod;
  logic signed [31:0] xi_eff;

  assign xi_eff = s1_iok ? $signed(s1_xi) : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_op   <= s1_op;
    s2_diag <= s1_diag;
    s2_last <= s1_last;
    s2_row  <= s1_row;
    s2_val  <= s1_val;
    s2_rhs  <= s1_rhs;
    s2_oldx <= s1_rok ? $signed(s1_xr) : 32'sd0;
    s2_prod <= s1_val * xi_eff;
  end

  // stage 3: accumulate, capture diagonal, hand row ends and empty rows to the queue
  logic signed [63:0] acc, acc_next;
  logic signed [31:0] diag, diag_next;
  logic               found, found_next;
  logic signed [64:0] sum65;
  logic signed [63:0] acc_sum;
  logic signed [31:0] diag_cur;
  logic               found_cur;

  always_comb begin
    sum65 = {acc[63], acc} + {s2_prod[63], s2_prod};
    if (sum65[64] != sum65[63]) begin
      acc_sum = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sum = sum65[63:0];
    end
    diag_cur  = (!found && s2_diag) ? s2_val : diag;
    found_cur = found | s2_diag;

    acc_next   = acc;
    diag_next  = diag;
    found_next = found;
    job_push   = 1'b0;
    job.empty_row = 1'b0;
    job.row   = s2_row;
    job.acc   = acc_sum;
    job.rhs   = s2_rhs;
    job.oldx  = s2_oldx;
    job.diag  = diag_cur;
    job.found = found_cur;
    if (s2_v) begin
      if (s2_op == cwj_pkg::OP_EMPTY_ROW) begin
        job_push = 1'b1;
        job.empty_row = 1'b1;
      end else if (s2_last) begin
        job_push   = 1'b1;
        acc_next   = 64'sd0;
        diag_next  = 32'sd0;
        found_next = 1'b0;
      end else begin
        acc_next   = acc_sum;
        diag_next  = diag_cur;
        found_next = found_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 64'sd0;
      diag  <= 32'sd0;
      found <= 1'b0;
    end else begin
      acc   <= acc_next;
      diag  <= diag_next;
      found <= found_next;
    end
  end

endmodule

// File: rtl/cwj_queue.sv
module cwj_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cwj_pkg::job_t din,
  input  logic          pop,
  output cwj_pkg::job_t dout,
  output logic          nonempty,
  output logic [cwj_pkg::QUEUE_AW:0] count
);

  cwj_pkg::job_t mem [cwj_pkg::QUEUE_DEPTH];
  logic [cwj_pkg::QUEUE_AW-1:0] wp, rp;
  logic do_pop;

  assign do_pop   = pop && count != '0;
  assign nonempty = count != '0;
  assign dout     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      count <= count + (cwj_pkg::QUEUE_AW+1)'(push) - (cwj_pkg::QUEUE_AW+1)'(do_pop);
    end
  end

endmodule

// File: rtl/cwj_back.sv
module cwj_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               omega_we,
  input  logic [17:0]        omega_wdata,
  input  logic               job_ready,
  input  cwj_pkg::job_t      job_in,
  output logic               job_pop,
  input  logic               pop,
  output logic               empty,
  output logic [9:0]         out_row,
  output logic signed [31:0] residual,
  output logic signed [31:0] new_x,
  output logic [1:0]         status
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RES  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_PREP = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_FIX  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  localparam int PW = 51;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -53'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [17:0]         omega;
  logic [2:0]          state;
  cwj_pkg::job_t       job;
  logic signed [31:0]  res, nx;
  logic [1:0]          st;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]       num;
  logic [31:0]         den;
  logic [32:0]         rem;
  logic [5:0]          cnt;
  logic                neg;
  logic                ov;

  // residual
  logic signed [65:0] d66;
  logic signed [63:0] diff;
  logic signed [48:0] r49;
  logic signed [31:0] res_c;

  always_comb begin
    d66 = $signed({{18{job.rhs[31]}}, job.rhs, 16'd0}) - $signed({{2{job.acc[63]}}, job.acc});
    if (d66[65:63] != 3'b000 && d66[65:63] != 3'b111) begin
      diff = d66[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      diff = d66[63:0];
    end
    r49 = $signed({diff[63], diff[63:16]}) + $signed({48'd0, diff[15]});
    if (job.empty_row) begin
      res_c = job.rhs;
    end else begin
      res_c = sat32({{4{r49[48]}}, r49});
    end
  end

  // divide step
  logic [32:0] rs;
  logic        ge;
  assign rs = {rem[31:0], num[PW-1]};
  assign ge = rs >= {1'b0, den};

  logic [PW:0]        qmag;
  logic signed [52:0] term, sum;
  assign qmag = {1'b0, num};
  assign term = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign sum  = $signed({{21{job.oldx[31]}}, job.oldx}) + term;

  assign job_pop = state == B_IDLE && job_ready;
  assign empty   = !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= 18'd43691;
    end else if (omega_we) begin
      omega <= omega_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      ov    <= 1'b0;
    end else begin
      if (pop && ov && state != B_OUT) ov <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (job_ready) begin
            job   <= job_in;
            state <= B_RES;
          end
        end
        B_RES: begin
          res <= res_c;
          nx  <= job.oldx;
          if (job.empty_row || !job.found) begin
            st    <= cwj_pkg::ST_NO_DIAG;
            state <= B_OUT;
          end else if (job.diag == 32'sd0) begin
            st    <= cwj_pkg::ST_ZERO_DIAG;
            state <= B_OUT;
          end else begin
            st    <= cwj_pkg::ST_UPDATED;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= $signed({1'b0, omega}) * res;
          state <= B_PREP;
        end
        B_PREP: begin
          neg   <= prod[PW-1] ^ job.diag[31];
          num   <= prod[PW-1] ? PW'(-prod) : PW'(prod);
          den   <= job.diag[31] ? 32'(-job.diag) : 32'(job.diag);
          rem   <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem <= ge ? rs - {1'b0, den} : rs;
          num <= {num[PW-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(PW - 1)) state <= B_FIX;
        end
        B_FIX: begin
          nx    <= sat32(sum);
          state <= B_OUT;
        end
        B_OUT: begin
          if (!ov || pop) begin
            ov       <= 1'b1;
            out_row  <= job.row;
            residual <= res;
            new_x    <= nx;
            status   <= st;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/cwj_checker.sv
module cwj_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [9:0]  out_row,
  input logic [31:0] residual,
  input logic [31:0] new_x,
  input logic [1:0]  status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_notfull: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_row) && $stable(residual) &&
                       $stable(new_x) && $stable(status))
    else $error("waiting result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status != 2'd3)
    else $error("illegal status");

endmodule

bind csr_weighted_jacobi_sweep_top cwj_checker u_cwj_checker (
  .clk, .rst, .full, .empty, .pop, .out_row, .residual, .new_x, .status
);
